### hdl/nearest_vertex_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest vertex search block
// Shared concurrent-check wrappers; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VERTEX_SEARCH_DEFINES_SVH
`define NEAREST_VERTEX_SEARCH_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define NVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle
`define NVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared constants, codes and control types of the nearest vertex search.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 16;
  localparam int IN_COORD_W   = 16;
  localparam int IDX_OUT_W    = 10;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = 3 * COORD_BITS;
  localparam int SQ_W         = 2 * COORD_BITS + 1;
  localparam int SUM_W        = SQ_W + 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } nvs_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } nvs_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } nvs_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic issue;    // read next stored vertex
    logic finish;   // load query result into the output register
  } nvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or draining this cycle
    logic count_zero;  // store is empty
    logic last_issue;  // current read address is the last stored vertex
    logic pipe_busy;   // distance pipeline still holds work
  } nvs_stat_t;

  // Take a 16-bit input coordinate as a COORD_BITS-bit signed value
  function automatic logic signed [COORD_BITS-1:0] to_coord(
    input logic signed [IN_COORD_W-1:0] raw
  );
    logic signed [31:0] wide;
    wide = 32'(raw);
    return wide[COORD_BITS-1:0];
  endfunction

endpackage

### hdl/nearest_vertex_search.sv
// Append, clear and empty-store query results load at the accepting edge.
// A query reads every stored vertex and loads its result once the pipeline has drained.
// A query holds off new transactions until its result loads; other transactions do not.
// Scan cost is one store read per vertex through the single RAM read port plus a 3-stage pipe.
// A result waiting on out_stall holds off the next transaction.
// Reset (synchronous, active high) empties the store count and drops any pending result.
// ----------------------------------------------------------------------------
// nearest_vertex_search
// Top level: vertex store with nearest-vertex query by squared distance.
// ----------------------------------------------------------------------------
module nearest_vertex_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic signed [15:0]            coord_x,
  input  logic signed [15:0]            coord_y,
  input  logic signed [15:0]            coord_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nvs_pkg::IDX_OUT_W-1:0] vertex_idx,
  output logic [1:0]                    status
);

  nvs_pkg::nvs_cmd_t  cmd;
  nvs_pkg::nvs_stat_t stat;

  nvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nvs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vertex_idx (vertex_idx),
    .status     (status)
  );

endmodule

### hdl/nvs_ram.sv
// ----------------------------------------------------------------------------
// nvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/nvs_ctrl.sv
// ----------------------------------------------------------------------------
// nvs_ctrl
// Sequencer: takes transactions, runs the store scan for queries, and
// hands the finished query result to the datapath output register.
// ----------------------------------------------------------------------------
module nvs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          op,
  output logic                in_stall,
  input  nvs_pkg::nvs_stat_t  stat,
  output nvs_pkg::nvs_cmd_t   cmd
);

  nvs_pkg::nvs_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      nvs_pkg::ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (nvs_pkg::nvs_op_t'(op) == nvs_pkg::OP_QUERY && !stat.count_zero) begin
            state_next = nvs_pkg::ST_SCAN;
          end
        end
      end
      nvs_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = nvs_pkg::ST_DRAIN;
        end
      end
      nvs_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = nvs_pkg::ST_DONE;
        end
      end
      nvs_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = nvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nvs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/nvs_datapath.sv
// ----------------------------------------------------------------------------
// nvs_datapath
// Vertex store, fill count, squared-distance pipeline, running minimum
// and the output register.
// ----------------------------------------------------------------------------
`include "nearest_vertex_search_defines.svh"

module nvs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  nvs_pkg::nvs_cmd_t                cmd,
  output nvs_pkg::nvs_stat_t               stat,
  input  logic [1:0]                       op,
  input  logic signed [15:0]               coord_x,
  input  logic signed [15:0]               coord_y,
  input  logic signed [15:0]               coord_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nvs_pkg::IDX_OUT_W-1:0]    vertex_idx,
  output logic [1:0]                       status
);

  logic [nvs_pkg::CNT_W-1:0]  count;
  logic [nvs_pkg::ADDR_W-1:0] rd_idx;

  logic signed [nvs_pkg::COORD_BITS-1:0] in_x, in_y, in_z;
  logic signed [nvs_pkg::COORD_BITS-1:0] qx, qy, qz;

  logic                       ram_we;
  logic [nvs_pkg::VTX_W-1:0]  ram_rdata;

  // pipeline stage valids and carried indexes
  logic                       v0, v1, v2;
  logic [nvs_pkg::ADDR_W-1:0] idx0, idx1, idx2;

  logic signed [nvs_pkg::COORD_BITS-1:0]   vx, vy, vz;
  logic signed [nvs_pkg::COORD_BITS:0]     dx, dy, dz;
  logic signed [2*nvs_pkg::COORD_BITS+1:0] px, py, pz;
  logic [nvs_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [nvs_pkg::SUM_W-1:0] dsum;

  logic                       have;
  logic [nvs_pkg::SUM_W-1:0]  best;
  logic [nvs_pkg::ADDR_W-1:0] best_idx;

  logic is_append, has_room;

  assign in_x = nvs_pkg::to_coord(coord_x);
  assign in_y = nvs_pkg::to_coord(coord_y);
  assign in_z = nvs_pkg::to_coord(coord_z);

  assign is_append = nvs_pkg::nvs_op_t'(op) == nvs_pkg::OP_APPEND;
  assign has_room  = count < nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES);
  assign ram_we    = cmd.accept && is_append && has_room;

  // status back to the controller
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.count_zero = count == '0;
  assign stat.last_issue = nvs_pkg::CNT_W'(rd_idx) == count - nvs_pkg::CNT_W'(1);
  assign stat.pipe_busy  = v0 || v1 || v2;

  nvs_ram #(
    .WIDTH (nvs_pkg::VTX_W),
    .DEPTH (nvs_pkg::MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[nvs_pkg::ADDR_W-1:0]),
    .wdata ({in_x, in_y, in_z}),
    .re    (cmd.issue),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      if (ram_we) begin
        count <= count + nvs_pkg::CNT_W'(1);
      end else if (nvs_pkg::nvs_op_t'(op) == nvs_pkg::OP_CLEAR) begin
        count <= '0;
      end
    end
  end

  // query point and scan address
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qx     <= in_x;
      qy     <= in_y;
      qz     <= in_z;
      rd_idx <= '0;
    end else if (cmd.issue) begin
      rd_idx <= rd_idx + nvs_pkg::ADDR_W'(1);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // stage 1: per-axis squared difference
  assign vx = ram_rdata[3*nvs_pkg::COORD_BITS-1:2*nvs_pkg::COORD_BITS];
  assign vy = ram_rdata[2*nvs_pkg::COORD_BITS-1:nvs_pkg::COORD_BITS];
  assign vz = ram_rdata[nvs_pkg::COORD_BITS-1:0];
  assign dx = {qx[nvs_pkg::COORD_BITS-1], qx} - {vx[nvs_pkg::COORD_BITS-1], vx};
  assign dy = {qy[nvs_pkg::COORD_BITS-1], qy} - {vy[nvs_pkg::COORD_BITS-1], vy};
  assign dz = {qz[nvs_pkg::COORD_BITS-1], qz} - {vz[nvs_pkg::COORD_BITS-1], vz};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    idx0 <= rd_idx;
    idx1 <= idx0;
    idx2 <= idx1;
    sq_x <= px[nvs_pkg::SQ_W-1:0];
    sq_y <= py[nvs_pkg::SQ_W-1:0];
    sq_z <= pz[nvs_pkg::SQ_W-1:0];
    // stage 2: distance sum
    dsum <= nvs_pkg::SUM_W'(sq_x) + nvs_pkg::SUM_W'(sq_y) + nvs_pkg::SUM_W'(sq_z);
  end

  // stage 3: running minimum, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.accept) begin
      have <= 1'b0;
    end else if (v2) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && (!have || dsum < best)) begin
      best     <= dsum;
      best_idx <= idx2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (cmd.accept) begin
      out_valid <= !(nvs_pkg::nvs_op_t'(op) == nvs_pkg::OP_QUERY && count != '0);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      vertex_idx <= nvs_pkg::IDX_OUT_W'(best_idx);
      status     <= nvs_pkg::STAT_OK;
    end else if (cmd.accept) begin
      vertex_idx <= '0;
      status     <= nvs_pkg::STAT_OK;
      unique case (nvs_pkg::nvs_op_t'(op))
        nvs_pkg::OP_APPEND: begin
          if (has_room) begin
            vertex_idx <= nvs_pkg::IDX_OUT_W'(count);
          end else begin
            status <= nvs_pkg::STAT_FULL;
          end
        end
        nvs_pkg::OP_QUERY: begin
          if (count == '0) begin
            status <= nvs_pkg::STAT_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `NVS_ASSERT(a_count_bound, count <= nvs_pkg::CNT_W'(nvs_pkg::MAX_VERTICES), "count over depth")
  `NVS_ASSERT(a_no_write_in_scan, !(ram_we && (v0 || v1 || v2 || cmd.issue)), "write during scan")
  `NVS_ASSERT(a_finish_has_best, !cmd.finish || (have && !(v0 || v1 || v2)), "result before scan end")
  `NVS_ASSERT_NEXT(a_append_count, ram_we, count == $past(count) + nvs_pkg::CNT_W'(1), "count not advanced")

endmodule
